FILE: sv/dsa_pkg.sv
// Shared types, constants and arithmetic helpers for the decimal scale aligner.
`timescale 1ns / 1ps
package dsa_pkg;

  localparam int MAX_SCALE = 28;
  localparam int MANT_W    = 96;
  localparam int SCALE_W   = 5;
  localparam int NUM_SLOTS = MAX_SCALE;
  localparam int REM_W     = 4;
  localparam int CHUNK_W   = 32;
  localparam int DIVIN_W   = CHUNK_W + REM_W;
  localparam logic [DIVIN_W-1:0] DIV10_RECIP = 36'hCCCCCCCCD;
  localparam int DIV10_SHIFT = 39;
  localparam logic [REM_W-1:0] REM_HALF = 4'd5;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic [MANT_W-1:0]  big;
    logic [MANT_W-1:0]  minor;
    logic [SCALE_W-1:0] s_big;
    logic [SCALE_W-1:0] s_small;
    logic               a_big;
    op_t                op;
    logic [REM_W-1:0]   rem;
  } item_t;

  // quotient in the upper bits, remainder in the low REM_W bits
  function automatic logic [DIVIN_W-1:0] div10(input logic [DIVIN_W-1:0] t);
    logic [2*DIVIN_W-1:0] p;
    logic [CHUNK_W-1:0]   q;
    logic [DIVIN_W-1:0]   q10;
    logic [DIVIN_W-1:0]   r;
    p   = {{DIVIN_W{1'b0}}, t} * {{DIVIN_W{1'b0}}, DIV10_RECIP};
    q   = p[DIV10_SHIFT +: CHUNK_W];
    q10 = ({{REM_W{1'b0}}, q} << 3) + ({{REM_W{1'b0}}, q} << 1);
    r   = t - q10;
    return {q, r[REM_W-1:0]};
  endfunction

endpackage

FILE: sv/dsa_step.sv
// One scale step: multiply by ten, divide by ten with rounding, or pass through unchanged, over four stages.
`timescale 1ns / 1ps
module dsa_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  dsa_pkg::item_t in_item,
  output logic          out_valid,
  output dsa_pkg::item_t out_item
);
  import dsa_pkg::*;

  logic  [3:0] vld;
  item_t       stg [0:3];
  item_t       stg_next [0:3];

  always_comb begin
    logic [MANT_W+2:0]  prod;
    logic               mul_ok;
    logic [DIVIN_W-1:0] d0;
    logic [DIVIN_W-1:0] d1;
    logic [DIVIN_W-1:0] d2;
    logic               tie;
    logic               inc;

    prod = ({3'b000, in_item.minor} << 3) + ({3'b000, in_item.minor} << 1);
    mul_ok = (in_item.s_big > in_item.s_small) &&
             (in_item.s_small < SCALE_W'(MAX_SCALE)) &&
             (in_item.minor[MANT_W-1 -: 3] == 3'b000) &&
             (prod[MANT_W+2:MANT_W] == 3'b000);
    d0 = div10({{REM_W{1'b0}}, in_item.big[MANT_W-1 -: CHUNK_W]});
    stg_next[0] = in_item;
    if (mul_ok) begin
      stg_next[0].minor   = prod[MANT_W-1:0];
      stg_next[0].s_small = in_item.s_small + 1'b1;
      stg_next[0].op      = OP_MUL;
    end else if (in_item.s_big > in_item.s_small) begin
      stg_next[0].big[MANT_W-1 -: CHUNK_W] = d0[DIVIN_W-1:REM_W];
      stg_next[0].rem = d0[REM_W-1:0];
      stg_next[0].op  = OP_DIV;
    end else begin
      stg_next[0].op = OP_NONE;
    end

    d1 = div10({stg[0].rem, stg[0].big[2*CHUNK_W-1 -: CHUNK_W]});
    stg_next[1] = stg[0];
    if (stg[0].op == OP_DIV) begin
      stg_next[1].big[2*CHUNK_W-1 -: CHUNK_W] = d1[DIVIN_W-1:REM_W];
      stg_next[1].rem = d1[REM_W-1:0];
    end

    d2 = div10({stg[1].rem, stg[1].big[CHUNK_W-1:0]});
    stg_next[2] = stg[1];
    if (stg[1].op == OP_DIV) begin
      stg_next[2].big[CHUNK_W-1:0] = d2[DIVIN_W-1:REM_W];
      stg_next[2].rem = d2[REM_W-1:0];
    end

    tie = (stg[2].s_big == stg[2].s_small + 1'b1) ? stg[2].minor[0] : 1'b0;
    inc = (stg[2].rem > REM_HALF) ||
          ((stg[2].rem == REM_HALF) && (stg[2].big[0] != tie));
    stg_next[3] = stg[2];
    if (stg[2].op == OP_DIV) begin
      stg_next[3].big   = stg[2].big + {{(MANT_W-1){1'b0}}, inc};
      stg_next[3].s_big = stg[2].s_big - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= stg_next[0];
      stg[1] <= stg_next[1];
      stg[2] <= stg_next[2];
      stg[3] <= stg_next[3];
    end
  end

  assign out_valid = vld[3];
  assign out_item  = stg[3];

endmodule

FILE: sv/decimal_scale_align_core.sv
// Each input passes the entry register and then the 28 step slots, in order, to the result.
// Each slot does one multiply-by-ten, one three-chunk divide-by-ten plus rounding, or nothing.
// Throughput: one transfer per cycle; the whole pipeline holds while the result waits.
// Reset: rst clears all valid bits synchronously; data registers are not reset.
`timescale 1ns / 1ps
module decimal_scale_align_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_mant_hi, a_mant_lo, a_scale, b_mant_hi, b_mant_lo, b_scale
  input  logic [207:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // a_out_hi, a_out_lo, b_out_hi, b_out_lo, common_scale
  output logic [199:0] m_tdata
);
  import dsa_pkg::*;

  logic               en;
  logic [SCALE_W-1:0] sa;
  logic [SCALE_W-1:0] sb;
  logic [MANT_W-1:0]  ma;
  logic [MANT_W-1:0]  mb;
  item_t              entry_next;
  item_t              entry;
  logic               entry_vld;
  logic               slot_vld  [0:NUM_SLOTS];
  item_t              slot_item [0:NUM_SLOTS];
  item_t              fin;
  logic [MANT_W-1:0]  out_a;
  logic [MANT_W-1:0]  out_b;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    ma = {s_tdata[31:0], s_tdata[95:32]};
    mb = {s_tdata[132:101], s_tdata[196:133]};
    sa = (s_tdata[100:96] > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : s_tdata[100:96];
    sb = (s_tdata[201:197] > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : s_tdata[201:197];
    entry_next.rem = '0;
    entry_next.op  = OP_NONE;
    if (sa >= sb) begin
      entry_next.big = ma; entry_next.s_big = sa;
      entry_next.minor = mb; entry_next.s_small = sb;
      entry_next.a_big = 1'b1;
    end else begin
      entry_next.big = mb; entry_next.s_big = sb;
      entry_next.minor = ma; entry_next.s_small = sa;
      entry_next.a_big = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= 1'b0;
    end else if (en) begin
      entry_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry <= entry_next;
    end
  end

  assign slot_vld[0]  = entry_vld;
  assign slot_item[0] = entry;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    dsa_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (slot_vld[g]),
      .in_item  (slot_item[g]),
      .out_valid(slot_vld[g+1]),
      .out_item (slot_item[g+1])
    );
  end

  assign fin      = slot_item[NUM_SLOTS];
  assign m_tvalid = slot_vld[NUM_SLOTS];

  always_comb begin
    out_a = fin.a_big ? fin.big : fin.minor;
    out_b = fin.a_big ? fin.minor : fin.big;
    m_tdata = '0;
    m_tdata[31:0]    = out_a[95:64];
    m_tdata[95:32]   = out_a[63:0];
    m_tdata[127:96]  = out_b[95:64];
    m_tdata[191:128] = out_b[63:0];
    m_tdata[196:192] = fin.s_big;
  end

endmodule
